@@ design/pal_lut_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Palette lookup package
// Shared constants, types and the entry encoder for the palette lookup block.
// ----------------------------------------------------------------------------
package pal_lut_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int ADDR_W          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int INDEX_W         = 8;
    localparam int COLOR_W         = 8;
    localparam int ENTRY_W         = 24;
    localparam int BYTES_W         = 3;
    localparam int FMT_W           = 2;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 2;

    localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

    localparam logic [FMT_W-1:0] FMT_RGB32 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_RGB24 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_RGB16 = 2'd2;
    localparam logic [FMT_W-1:0] FMT_RGB15 = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_FORMAT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PALETTE_ATTACHED = 1'd1;

    localparam logic [0:0] CMD_PIXEL = 1'b0;
    localparam logic [0:0] CMD_WRITE = 1'b1;

    localparam logic [BYTES_W-1:0] BYTES_FOUR  = 3'd4;
    localparam logic [BYTES_W-1:0] BYTES_THREE = 3'd3;
    localparam logic [BYTES_W-1:0] BYTES_TWO   = 3'd2;

    localparam logic [COLOR_W-1:0] MASK_FIVE = 8'hF8;
    localparam logic [COLOR_W-1:0] MASK_SIX  = 8'hFC;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [ENTRY_W-1:0] data;
    } pal_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } pal_rd_t;

    function automatic logic [ENTRY_W-1:0] encode_entry(
        input logic [COLOR_W-1:0] r,
        input logic [COLOR_W-1:0] g,
        input logic [COLOR_W-1:0] b,
        input logic [FMT_W-1:0]   fmt
    );
        logic [COLOR_W-1:0] r5;
        logic [COLOR_W-1:0] g6;
        logic [COLOR_W-1:0] g5;
        logic [COLOR_W-1:0] b5;
        logic [ENTRY_W-1:0] word;
        r5 = r & MASK_FIVE;
        g6 = g & MASK_SIX;
        g5 = g & MASK_FIVE;
        b5 = b & MASK_FIVE;
        case (fmt)
            FMT_RGB16: begin
                word = {8'h00, r5[7:3], g6[7:2], b5[7:3]};
            end
            FMT_RGB15: begin
                word = {8'h00, 1'b0, r5[7:3], g5[7:3], b5[7:3]};
            end
            default: begin
                word = {r, g, b};
            end
        endcase
        return word;
    endfunction

endpackage
`default_nettype wire

@@ design/palette_lookup_pixel_converter_top.sv @@
`default_nettype none
// A pixel transaction's result passes through the registered store read and then the output register.
// One transaction per cycle is accepted through the single input channel while the output is not stalled by m_ready.
// Palette writes complete at acceptance and give no result.
// Reset clears the configuration registers and the pipeline valid flags.
// Palette contents are undefined after reset until written.
// ----------------------------------------------------------------------------
// Palette lookup pixel converter
// Stores palette entries in screen format and looks up indexed pixels.
// ----------------------------------------------------------------------------
module palette_lookup_pixel_converter_top
    import pal_lut_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_cmd,
    input  wire logic [INDEX_W-1:0]     s_color_index,
    input  wire logic [COLOR_W-1:0]     s_red,
    input  wire logic [COLOR_W-1:0]     s_green,
    input  wire logic [COLOR_W-1:0]     s_blue,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [ENTRY_W-1:0]          m_screen_pixel,
    output logic [BYTES_W-1:0]          m_pixel_bytes
);

    logic [FMT_W-1:0]   fmt_reg;
    logic               attached_reg;

    logic               p1_valid_reg;
    logic               p1_valid_next;
    logic [FMT_W-1:0]   p1_fmt_reg;
    logic               p1_hit_reg;

    logic               m_valid_reg;
    logic               m_valid_next;
    logic [ENTRY_W-1:0] m_pixel_reg;
    logic [BYTES_W-1:0] m_bytes_reg;

    logic               s_accept;
    logic               pix_accept;
    logic               in_range;
    logic               advance;
    logic [ENTRY_W-1:0] rd_data;
    logic [ENTRY_W-1:0] pixel_value;
    logic [BYTES_W-1:0] bytes_value;
    pal_wr_t            wr_req;
    pal_rd_t            rd_req;

    assign advance    = !m_valid_reg || m_ready;
    assign s_ready    = !p1_valid_reg || advance;
    assign s_accept   = s_valid && s_ready;
    assign pix_accept = s_accept && (s_cmd == CMD_PIXEL);
    assign in_range   = {1'b0, s_color_index} < ENTRY_LIMIT;

    always_comb begin
        wr_req.en   = s_accept && (s_cmd == CMD_WRITE) && in_range;
        wr_req.addr = s_color_index[ADDR_W-1:0];
        wr_req.data = encode_entry(s_red, s_green, s_blue, fmt_reg);
        rd_req.en   = pix_accept;
        rd_req.addr = s_color_index[ADDR_W-1:0];
    end

    pal_lut_store u_store (
        .aclk    (aclk),
        .wr      (wr_req),
        .rd      (rd_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg      <= FMT_RGB32;
            attached_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SCREEN_FORMAT: begin
                    fmt_reg <= cfg_wdata[FMT_W-1:0];
                end
                CFG_PALETTE_ATTACHED: begin
                    attached_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (pix_accept) begin
            p1_valid_next = 1'b1;
        end else if (advance) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_accept) begin
            p1_fmt_reg <= fmt_reg;
            p1_hit_reg <= attached_reg && in_range;
        end
    end

    always_comb begin
        pixel_value = '0;
        if (p1_hit_reg) begin
            pixel_value = rd_data;
        end
        case (p1_fmt_reg)
            FMT_RGB32: begin
                bytes_value = BYTES_FOUR;
            end
            FMT_RGB24: begin
                bytes_value = BYTES_THREE;
            end
            default: begin
                bytes_value = BYTES_TWO;
                pixel_value = {8'h00, pixel_value[15:0]};
            end
        endcase
    end

    always_comb begin
        if (p1_valid_reg && advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_valid_reg && advance) begin
            m_pixel_reg <= pixel_value;
            m_bytes_reg <= bytes_value;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_screen_pixel = m_pixel_reg;
    assign m_pixel_bytes  = m_bytes_reg;

endmodule
`default_nettype wire

@@ design/pal_lut_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Palette entry store
// Single-clock memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pal_lut_store
    import pal_lut_pkg::*;
(
    input  wire logic                aclk,
    input  wire pal_wr_t             wr,
    input  wire pal_rd_t             rd,
    output logic [ENTRY_W-1:0]       rd_data
);

    logic [ENTRY_W-1:0] mem [PALETTE_ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
`default_nettype wire
